// File: sv/b64e_pkg.sv
`default_nettype none

package b64e_pkg;

  localparam int GQ_DEPTH = 2;
  localparam int GQ_AW    = $clog2(GQ_DEPTH);

  localparam logic [6:0] PAD_CHAR = 7'd61;

  // One complete or end-of-buffer group handed from front to back.
  typedef struct packed {
    logic [23:0] bits;    // b0,b1,b2, first byte in the top bits
    logic [1:0]  nbytes;  // data bytes in the group, 1..3
    logic        last;    // group closes the buffer
  } group_t;

  function automatic logic [6:0] b64_char(input logic [5:0] v);
    logic [6:0] c;
    if (v < 6'd26)      c = 7'd65 + {1'b0, v};
    else if (v < 6'd52) c = 7'd71 + {1'b0, v};   // 'a' - 26
    else if (v < 6'd62) c = {1'b0, v} - 7'd4;    // '0' - 52
    else if (v == 6'd62) c = 7'd43;
    else                 c = 7'd47;
    return c;
  endfunction

endpackage

`default_nettype wire

// File: sv/base64_stream_encoder.sv
`default_nettype none

// Base64 encoder with '=' padding, one input byte per cycle while not full and one output
// character per cycle while popped. A group's first character shows once its closing byte
// has passed the group queue, the group register in the back end and the output register.
// Bytes are taken every cycle while the group queue has room; every group, a padded end
// group too, yields four output characters, so sustained intake is three bytes per four.
// Reset: synchronous, active low; clears the byte count, queue and output stage.
module base64_stream_encoder
  import b64e_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  // input item channel
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] in_data_byte,
  input  wire logic       in_end_of_buffer,
  // result item channel
  output logic            empty,
  input  wire logic       pop,
  output logic [6:0]      out_char,
  output logic            out_run_last,
  output logic            out_stream_last
);

  logic   accept;
  logic   grp_push;
  group_t grp;
  group_t head;
  logic   q_full, q_empty;
  logic   head_take;

  // Full is the queue's full flag; a byte that only fills a pending slot could
  // slip in, but holding it off keeps full free of any path from the payload.
  assign full   = q_full;
  assign accept = push && !full;

  // Front: collects bytes into groups, emits a group on the third byte or on end of buffer.
  b64e_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .data_byte     (in_data_byte),
    .end_of_buffer (in_end_of_buffer),
    .grp_push      (grp_push),
    .grp           (grp)
  );

  // Short queue of ready groups decouples intake from character output.
  b64e_gq u_gq (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (grp_push),
    .wr_data (grp),
    .rd_en   (head_take),
    .rd_data (head),
    .q_full  (q_full),
    .q_empty (q_empty)
  );

  // Back: walks the four sextets of a group, padding past the data bytes,
  // through a registered output stage.
  b64e_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head            (head),
    .head_valid      (!q_empty),
    .head_take       (head_take),
    .pop             (pop),
    .empty           (empty),
    .out_char        (out_char),
    .out_run_last    (out_run_last),
    .out_stream_last (out_stream_last)
  );

endmodule

`default_nettype wire

// File: sv/b64e_front.sv
`default_nettype none

module b64e_front
  import b64e_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       accept,
  input  wire logic [7:0] data_byte,
  input  wire logic       end_of_buffer,
  output logic            grp_push,
  output group_t          grp
);

  logic [1:0] count_r;
  logic [1:0] count_nxt;
  logic [7:0] pend_r [2];
  logic [1:0] n;
  logic       store;
  logic [7:0] b0, b1, b2;

  assign n     = count_r + 2'd1;
  assign store = (n != 2'd3) && !end_of_buffer;

  always_comb begin
    b0 = (n == 2'd1) ? data_byte : pend_r[0];
    b1 = (n == 2'd2) ? data_byte : ((n == 2'd3) ? pend_r[1] : 8'd0);
    b2 = (n == 2'd3) ? data_byte : 8'd0;
  end

  assign grp_push    = accept && !store;
  assign grp.bits    = {b0, b1, b2};
  assign grp.nbytes  = n;
  assign grp.last    = end_of_buffer;

  always_comb begin
    count_nxt = count_r;
    if (accept) begin
      count_nxt = store ? n : 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 2'd0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // pending bytes need no reset: the count guards every read
  always_ff @(posedge clk) begin
    if (accept && store) begin
      pend_r[count_r[0]] <= data_byte;
    end
  end

endmodule

`default_nettype wire

// File: sv/b64e_gq.sv
`default_nettype none

module b64e_gq
  import b64e_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   wr_en,
  input  wire group_t wr_data,
  input  wire logic   rd_en,
  output group_t      rd_data,
  output logic        q_full,
  output logic        q_empty
);

  group_t             mem_r [GQ_DEPTH];
  logic [GQ_AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [GQ_AW:0]     cnt_r;

  assign q_full  = (cnt_r == (GQ_AW+1)'(GQ_DEPTH));
  assign q_empty = (cnt_r == '0);
  assign rd_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= (wr_ptr_r == GQ_AW'(GQ_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (rd_en) begin
        rd_ptr_r <= (rd_ptr_r == GQ_AW'(GQ_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({wr_en, rd_en})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

`default_nettype wire

// File: sv/b64e_back.sv
`default_nettype none

module b64e_back
  import b64e_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire group_t     head,
  input  wire logic       head_valid,
  output logic            head_take,
  input  wire logic       pop,
  output logic            empty,
  output logic [6:0]      out_char,
  output logic            out_run_last,
  output logic            out_stream_last
);

  group_t     grp_r;
  logic       busy_r;
  logic [1:0] k_r;
  logic       ovalid_r;
  logic [6:0] ochar_r;
  logic       orun_r, olast_r;

  logic       advance;
  logic       done;
  logic [5:0] sextet;
  logic [6:0] chr;

  assign advance   = busy_r && (!ovalid_r || pop);
  assign done      = advance && (k_r == 2'd3);
  assign head_take = head_valid && (!busy_r || done);

  always_comb begin
    case (k_r)
      2'd0:    sextet = grp_r.bits[23:18];
      2'd1:    sextet = grp_r.bits[17:12];
      2'd2:    sextet = grp_r.bits[11:6];
      default: sextet = grp_r.bits[5:0];
    endcase
  end

  assign chr = (k_r <= grp_r.nbytes) ? b64_char(sextet) : PAD_CHAR;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      k_r      <= 2'd0;
      ovalid_r <= 1'b0;
    end else begin
      if (head_take) begin
        busy_r <= 1'b1;
        k_r    <= 2'd0;
      end else if (done) begin
        busy_r <= 1'b0;
      end else if (advance) begin
        k_r <= k_r + 2'd1;
      end
      if (advance) begin
        ovalid_r <= 1'b1;
      end else if (pop) begin
        ovalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (head_take) begin
      grp_r <= head;
    end
    if (advance) begin
      ochar_r <= chr;
      orun_r  <= (k_r == 2'd3);
      olast_r <= (k_r == 2'd3) && grp_r.last;
    end
  end

  assign empty           = !ovalid_r;
  assign out_char        = ochar_r;
  assign out_run_last    = orun_r;
  assign out_stream_last = olast_r;

endmodule

`default_nettype wire
